// ===== rtl/rtpe_pkg.sv =====
// Package for the register table with patch and erase.
// Table sizing constants, command/status codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package rtpe_pkg;

    // Table sizing
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // Fixed field widths
    localparam int ADDR_W  = 32;
    localparam int VALUE_W = 32;
    localparam int RIDX_W  = 8;
    localparam int WORD_W  = ADDR_W + VALUE_W;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_PATCH = 2'd1,
        CMD_ERASE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_PREAD,
        S_PCMP,
        S_EREAD,
        S_ECMP,
        S_SREAD,
        S_SWRITE,
        S_RESP
    } state_t;

endpackage

// ===== rtl/register_table_patch_erase_top.sv =====
// Top level of the register table: command sequencer, table memory and result register.
// Depends on rtpe_pkg.
`timescale 1ns / 1ps

// Usage
// Input channel (item_valid / item_stall) takes one command word: load, patch,
// erase or read. Output channel (result_valid / result_stall) returns exactly
// one result word per command: status, read address/value and entry total.
// One command is in work at a time; item_stall stays high from acceptance until
// the result has been moved into the output register.
// Command steps: load writes the next free entry; a read in range fetches its
// entry from the table memory. Patch and erase search one entry at a time, each
// entry read (S_PREAD / S_EREAD) and then compared (S_PCMP / S_ECMP); after an
// erase hit each later entry is shifted down with a read (S_SREAD) and a write
// (S_SWRITE). The next command can be taken in the cycle result_valid rises.
// While result_stall is high a finished result is held in the output register;
// the next command is accepted and worked, and waits at the end for the
// output register to free up.
// Reset clears the entry count, both search positions and the handshakes.
// Table contents are not cleared; only entries below the count are ever used.
module register_table_patch_erase_top
    import rtpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         command,
    input  logic               first_of_batch,
    input  logic [ADDR_W-1:0]  reg_addr,
    input  logic [VALUE_W-1:0] reg_value,
    input  logic [RIDX_W-1:0]  read_index,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         status,
    output logic [ADDR_W-1:0]  out_addr,
    output logic [VALUE_W-1:0] out_value,
    output logic [CNT_W-1:0]   entry_total
);

    // Sequencer and control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   patch_start_reg, patch_start_next;
    logic [CNT_W-1:0]   erase_limit_reg, erase_limit_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic               result_valid_reg, result_valid_next;

    // Latched command word
    cmd_t               cmd_reg;
    logic               first_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [RIDX_W-1:0]  idx_reg;

    // Working result and output register
    status_t            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    status_t            status_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [CNT_W-1:0]   total_reg;

    // Table memory: address in the upper half, value in the lower half
    logic [WORD_W-1:0]  mem [TABLE_DEPTH];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [WORD_W-1:0]  rd_data_reg;

    logic               accept;
    logic               out_free;
    logic               hit;
    logic [CNT_W-1:0]   ptr_inc;
    logic [CNT_W-1:0]   ptr_dec;
    logic [CNT_W-1:0]   erase_lim;

    assign accept   = item_valid && !item_stall;
    assign out_free = !result_valid_reg || !result_stall;
    assign hit      = (rd_data_reg[WORD_W-1:VALUE_W] == addr_reg);
    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign ptr_dec  = ptr_reg - CNT_W'(1);
    assign erase_lim = first_reg ? count_reg :
                       ((erase_limit_reg > count_reg) ? count_reg : erase_limit_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_LOAD:  state_next = S_RESP;
                    CMD_PATCH: state_next = S_PREAD;
                    CMD_ERASE: state_next = S_EREAD;
                    CMD_READ:
                    begin
                        if (32'(idx_reg) < 32'(count_reg))
                            state_next = S_RDWAIT;
                        else
                            state_next = S_RESP;
                    end
                    default:   state_next = S_RESP;
                endcase
            end
            S_RDWAIT: state_next = S_RESP;
            S_PREAD:
            begin
                if (ptr_reg >= count_reg)
                    state_next = S_RESP;
                else
                    state_next = S_PCMP;
            end
            S_PCMP:   state_next = hit ? S_RESP : S_PREAD;
            S_EREAD:
            begin
                if (ptr_reg == '0)
                    state_next = S_RESP;
                else
                    state_next = S_ECMP;
            end
            S_ECMP:   state_next = hit ? S_SREAD : S_EREAD;
            S_SREAD:
            begin
                if (ptr_inc >= count_reg)
                    state_next = S_RESP;
                else
                    state_next = S_SWRITE;
            end
            S_SWRITE: state_next = S_SREAD;
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath control per state
    always_comb
    begin
        count_next        = count_reg;
        patch_start_next  = patch_start_reg;
        erase_limit_next  = erase_limit_reg;
        ptr_next          = ptr_reg;
        res_status_next   = res_status_reg;
        res_addr_next     = res_addr_reg;
        res_value_next    = res_value_reg;
        result_valid_next = result_valid_reg && result_stall;
        mem_we            = 1'b0;
        mem_waddr         = ptr_reg[IDX_W-1:0];
        mem_wdata         = {addr_reg, value_reg};
        mem_raddr         = ptr_reg[IDX_W-1:0];
        item_stall        = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                res_status_next = STAT_OK;
                res_addr_next   = '0;
                res_value_next  = '0;
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_LOAD:
                    begin
                        if (count_reg < CNT_W'(TABLE_DEPTH))
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                            res_status_next = STAT_FULL;
                    end
                    CMD_PATCH:
                    begin
                        // batch start resets the search position even on a miss
                        if (first_reg)
                        begin
                            patch_start_next = '0;
                            ptr_next         = '0;
                        end
                        else
                            ptr_next = patch_start_reg;
                    end
                    CMD_ERASE:
                    begin
                        if (first_reg)
                            erase_limit_next = count_reg;
                        ptr_next = erase_lim;
                    end
                    CMD_READ:
                    begin
                        mem_raddr = IDX_W'(idx_reg);
                        if (!(32'(idx_reg) < 32'(count_reg)))
                            res_status_next = STAT_RANGE;
                    end
                    default: ;
                endcase
            end
            S_RDWAIT:
            begin
                res_addr_next  = rd_data_reg[WORD_W-1:VALUE_W];
                res_value_next = rd_data_reg[VALUE_W-1:0];
            end
            S_PREAD:
            begin
                if (ptr_reg >= count_reg)
                    res_status_next = STAT_NOT_FOUND;
            end
            S_PCMP:
            begin
                if (hit)
                begin
                    mem_we           = 1'b1;
                    patch_start_next = ptr_inc;
                end
                else
                    ptr_next = ptr_inc;
            end
            S_EREAD:
            begin
                mem_raddr = ptr_dec[IDX_W-1:0];
                if (ptr_reg == '0)
                    res_status_next = STAT_NOT_FOUND;
            end
            S_ECMP:
            begin
                // hit at ptr-1: that position becomes the new bound and the shift start
                if (hit)
                    erase_limit_next = ptr_dec;
                ptr_next = ptr_dec;
            end
            S_SREAD:
            begin
                mem_raddr = ptr_inc[IDX_W-1:0];
                if (ptr_inc >= count_reg)
                    count_next = count_reg - CNT_W'(1);
            end
            S_SWRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                ptr_next  = ptr_inc;
            end
            S_RESP:
            begin
                if (out_free)
                    result_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            patch_start_reg  <= '0;
            erase_limit_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            patch_start_reg  <= patch_start_next;
            erase_limit_reg  <= erase_limit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(command);
            first_reg <= first_of_batch;
            addr_reg  <= reg_addr;
            value_reg <= reg_value;
            idx_reg   <= read_index;
        end
        ptr_reg        <= ptr_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_value_reg  <= res_value_next;
        if (state_reg == S_RESP && out_free)
        begin
            status_reg    <= res_status_reg;
            out_addr_reg  <= res_addr_reg;
            out_value_reg <= res_value_reg;
            total_reg     <= count_reg;
        end
    end

    // Table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign out_addr     = out_addr_reg;
    assign out_value    = out_value_reg;
    assign entry_total  = total_reg;

endmodule

// ===== rtl/rtpe_checker.sv =====
// Port-level checker for the register table, bound to the top level.
// Depends on rtpe_pkg and register_table_patch_erase_top.
`timescale 1ns / 1ps

module rtpe_checker
    import rtpe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic [1:0]         status,
    input logic [ADDR_W-1:0]  out_addr,
    input logic [VALUE_W-1:0] out_value,
    input logic [CNT_W-1:0]   entry_total
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(status) && $stable(out_addr)
            && $stable(out_value) && $stable(entry_total))
        else $error("stalled result word changed");

    // one command in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("command accepted while another is in work");

    // address and value only come back on a good read
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != STAT_OK |-> out_addr == '0 && out_value == '0)
        else $error("nonzero read data with error status");

    // entry total never above depth, full only when at depth
    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> entry_total <= CNT_W'(TABLE_DEPTH))
        else $error("entry total above table depth");

    a_full_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STAT_FULL |-> entry_total == CNT_W'(TABLE_DEPTH))
        else $error("full status below table depth");

endmodule

bind register_table_patch_erase_top rtpe_checker u_rtpe_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the register table with ordered patch and erase.
// Scoreboard class predicts every result word; tasks drive commands in bursts.
// Depends on rtpe_pkg and register_table_patch_erase_top.
`timescale 1ns / 1ps

module testbench;
    import rtpe_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int ITEM_GOAL  = 1700;
    localparam int FILL_START = 1200;
    localparam int POOL_SIZE  = 6;

    // one expected result word
    typedef struct packed {
        logic [1:0]         st;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   total;
    } table_result_t;

    // Table predictor and in-order result checker
    class table_scoreboard;
        logic [ADDR_W-1:0]  addr_mem  [TABLE_DEPTH];
        logic [VALUE_W-1:0] value_mem [TABLE_DEPTH];
        int unsigned        count;
        int unsigned        patch_pos;
        int unsigned        erase_bound;
        table_result_t      awaited [$];
        int                 errors;

        function new();
            int i;
            for (i = 0; i < TABLE_DEPTH; i++)
            begin
                addr_mem[i]  = '0;
                value_mem[i] = '0;
            end
            count       = 0;
            patch_pos   = 0;
            erase_bound = 0;
            errors      = 0;
        endfunction

        // work out the result of one accepted command word
        function void note_command(logic [1:0] cmd, logic first, logic [ADDR_W-1:0] a,
                                   logic [VALUE_W-1:0] v, logic [RIDX_W-1:0] idx);
            table_result_t r;
            int unsigned   j;
            int unsigned   k;
            int unsigned   lim;
            bit            hit;
            r.st    = STAT_OK;
            r.addr  = '0;
            r.value = '0;
            hit     = 1'b0;
            if (count > TABLE_DEPTH)
                count = TABLE_DEPTH;
            case (cmd)
                CMD_LOAD:
                begin
                    if (count < TABLE_DEPTH)
                    begin
                        addr_mem[count]  = a;
                        value_mem[count] = v;
                        count++;
                    end
                    else
                        r.st = STAT_FULL;
                end
                CMD_PATCH:
                begin
                    if (first)
                        patch_pos = 0;
                    r.st = STAT_NOT_FOUND;
                    for (j = patch_pos; j < count && !hit; j++)
                    begin
                        if (addr_mem[j] == a)
                        begin
                            value_mem[j] = v;
                            patch_pos    = j + 1;
                            r.st         = STAT_OK;
                            hit          = 1'b1;
                        end
                    end
                end
                CMD_ERASE:
                begin
                    if (first)
                        erase_bound = count;
                    // a bound left above the count is clipped to it
                    lim  = (erase_bound > count) ? count : erase_bound;
                    r.st = STAT_NOT_FOUND;
                    for (j = lim; j > 0 && !hit; j--)
                    begin
                        if (addr_mem[j-1] == a)
                        begin
                            for (k = j - 1; k + 1 < count; k++)
                            begin
                                addr_mem[k]  = addr_mem[k+1];
                                value_mem[k] = value_mem[k+1];
                            end
                            count--;
                            erase_bound = j - 1;
                            r.st        = STAT_OK;
                            hit         = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (idx < count)
                    begin
                        r.addr  = addr_mem[idx];
                        r.value = value_mem[idx];
                    end
                    else
                        r.st = STAT_RANGE;
                end
            endcase
            r.total = CNT_W'(count);
            awaited.push_back(r);
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_result(logic [1:0] st, logic [ADDR_W-1:0] a,
                                   logic [VALUE_W-1:0] v, logic [CNT_W-1:0] total);
            table_result_t r;
            if (awaited.size() == 0)
            begin
                $error("result word arrived with no command outstanding");
                errors++;
            end
            else
            begin
                r = awaited.pop_front();
                if (st !== r.st)
                begin
                    $error("status: expected %0d, actual %0d", r.st, st);
                    errors++;
                end
                if (a !== r.addr)
                begin
                    $error("out_addr: expected %h, actual %h", r.addr, a);
                    errors++;
                end
                if (v !== r.value)
                begin
                    $error("out_value: expected %h, actual %h", r.value, v);
                    errors++;
                end
                if (total !== r.total)
                begin
                    $error("entry_total: expected %0d, actual %0d", r.total, total);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [1:0]         command;
    logic               first_of_batch;
    logic [ADDR_W-1:0]  reg_addr;
    logic [VALUE_W-1:0] reg_value;
    logic [RIDX_W-1:0]  read_index;
    logic               result_valid;
    logic               result_stall;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  out_addr;
    logic [VALUE_W-1:0] out_value;
    logic [CNT_W-1:0]   entry_total;

    table_scoreboard    sb;
    logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];
    int                 sent_items;
    int                 burst_left;
    bit                 valid_held;
    int                 idle_cycles;
    int                 stall_cycle;
    int                 stall_mode;

    register_table_patch_erase_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command        (command),
        .first_of_batch (first_of_batch),
        .reg_addr       (reg_addr),
        .reg_value      (reg_value),
        .read_index     (read_index),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .out_addr       (out_addr),
        .out_value      (out_value),
        .entry_total    (entry_total)
    );

    always #10 clk = ~clk;

    // Monitor both channels and the idle watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles = idle_cycles + 1;
            if (item_valid && !item_stall)
            begin
                sb.note_command(command, first_of_batch, reg_addr, reg_value, read_index);
                idle_cycles = 0;
            end
            if (result_valid && !result_stall)
            begin
                sb.check_result(status, out_addr, out_value, entry_total);
                idle_cycles = 0;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver stall: pattern drawn at random from five modes
    always @(posedge clk)
    begin
        stall_cycle = stall_cycle + 1;
        if (stall_cycle % 150 == 0)
            stall_mode = $urandom_range(0, 4);
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            2:       result_stall <= ($urandom_range(0, 3) != 0);
            3:       result_stall <= ((stall_cycle % 5) < 2);
            default: result_stall <= ((stall_cycle % 40) < 30);
        endcase
    end

    // Present one command word, hold it until taken, then maybe open a gap
    task automatic send_command(logic [1:0] c, logic f, logic [ADDR_W-1:0] a,
                                logic [VALUE_W-1:0] v, logic [RIDX_W-1:0] idx);
        int gap;
        command        <= c;
        first_of_batch <= f;
        reg_addr       <= a;
        reg_value      <= v;
        read_index     <= idx;
        item_valid     <= 1'b1;
        valid_held      = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_items++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 10);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                valid_held  = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic load_entry(logic [ADDR_W-1:0] a, logic [VALUE_W-1:0] v);
        send_command(CMD_LOAD, 1'($urandom_range(0, 1)), a, v, RIDX_W'($urandom_range(0, 255)));
    endtask

    task automatic patch_entry(logic f, logic [ADDR_W-1:0] a, logic [VALUE_W-1:0] v);
        send_command(CMD_PATCH, f, a, v, RIDX_W'($urandom_range(0, 255)));
    endtask

    task automatic erase_entry(logic f, logic [ADDR_W-1:0] a);
        send_command(CMD_ERASE, f, a, $urandom, RIDX_W'($urandom_range(0, 255)));
    endtask

    task automatic read_entry(logic [RIDX_W-1:0] idx);
        send_command(CMD_READ, 1'($urandom_range(0, 1)), $urandom, $urandom, idx);
    endtask

    // Mostly a known address, sometimes any address
    function automatic logic [ADDR_W-1:0] pool_addr();
        if ($urandom_range(0, 4) != 0)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic refresh_pool();
        int i;
        for (i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;
        if ($urandom_range(0, 2) == 0)
            addr_pool[0] = '0;
        if ($urandom_range(0, 2) == 0)
            addr_pool[1] = '1;
    endtask

    // First flag: set on the head of a list, rarely elsewhere
    function automatic logic list_flag(int pos);
        if (pos == 0)
            return ($urandom_range(0, 9) != 0);
        return ($urandom_range(0, 9) == 0);
    endfunction

    // One round: loads, an ordered patch list, a backward erase list, reads
    task automatic run_batch();
        int               n;
        int               p;
        int               i;
        logic [ADDR_W-1:0] a;
        if ($urandom_range(0, 3) == 0)
            refresh_pool();
        // keep the table short so scans stay cheap
        while (sb.count > 32)
            erase_entry(1'b1, sb.addr_mem[sb.count - 1]);
        n = (sb.count > 28) ? 0 : $urandom_range(0, 8);
        repeat (n) load_entry(pool_addr(), $urandom);

        // patch list walking forward through the table
        n = $urandom_range(1, 6);
        p = $urandom_range(0, 2);
        for (i = 0; i < n; i++)
        begin
            if (p < int'(sb.count) && $urandom_range(0, 6) != 0)
                a = sb.addr_mem[p];
            else
                a = pool_addr();
            patch_entry(list_flag(i), a, $urandom);
            p += $urandom_range(1, 3);
        end

        // erase list walking backward from the end
        n = $urandom_range(0, 4);
        p = int'(sb.count) - 1 - $urandom_range(0, 2);
        for (i = 0; i < n; i++)
        begin
            if (p >= 0 && p < int'(sb.count) && $urandom_range(0, 6) != 0)
                a = sb.addr_mem[p];
            else
                a = pool_addr();
            erase_entry(list_flag(i), a);
            p -= $urandom_range(1, 3);
        end

        n = $urandom_range(1, 4);
        repeat (n)
        begin
            if (sb.count > 0 && $urandom_range(0, 3) != 0)
                read_entry(RIDX_W'($urandom_range(0, sb.count - 1)));
            else
                read_entry(RIDX_W'($urandom_range(0, 255)));
        end

        // noise word
        if ($urandom_range(0, 4) == 0)
            send_command(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), pool_addr(),
                         $urandom, RIDX_W'($urandom_range(0, 255)));
    endtask

    // Fill to full, hit the full case, work on the full table, refill
    task automatic fill_phase();
        int               p;
        int               i;
        logic [ADDR_W-1:0] a;
        refresh_pool();
        while (sb.count < TABLE_DEPTH)
            load_entry(($urandom_range(0, 1) != 0) ? pool_addr() : $urandom, $urandom);
        repeat (3) load_entry($urandom, $urandom);
        read_entry(RIDX_W'(TABLE_DEPTH - 1));
        read_entry('0);
        read_entry(RIDX_W'($urandom_range(0, 255)));
        p = $urandom_range(0, 20);
        for (i = 0; i < 10; i++)
        begin
            a = (p < TABLE_DEPTH) ? sb.addr_mem[p] : pool_addr();
            patch_entry(i == 0, a, $urandom);
            p += $urandom_range(1, 30);
        end
        p = TABLE_DEPTH - 1 - $urandom_range(0, 5);
        for (i = 0; i < 6; i++)
        begin
            a = (p >= 0) ? sb.addr_mem[p] : pool_addr();
            erase_entry(i == 0, a);
            p -= $urandom_range(1, 20);
        end
        while (sb.count < TABLE_DEPTH)
            load_entry($urandom, $urandom);
        load_entry($urandom, $urandom);
        patch_entry(1'b1, sb.addr_mem[TABLE_DEPTH - 1], $urandom);
        read_entry(RIDX_W'(TABLE_DEPTH - 1));
    endtask

    // Stimulus and end of run
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        result_stall   = 1'b0;
        command        = CMD_LOAD;
        first_of_batch = 1'b0;
        reg_addr       = '0;
        reg_value      = '0;
        read_index     = '0;
        sent_items     = 0;
        burst_left     = 1;
        valid_held     = 1'b0;
        idle_cycles    = 0;
        stall_cycle    = 0;
        stall_mode     = 0;
        sb             = new();
        refresh_pool();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, field extremes, batch search positions
        read_entry('0);
        patch_entry(1'b1, 32'h1234_0000, 32'h1);
        erase_entry(1'b1, 32'h1234_0000);
        load_entry(32'h0000_0000, 32'hFFFF_FFFF);
        load_entry(32'hFFFF_FFFF, 32'h0000_0000);
        load_entry(32'hA5A5_A5A5, 32'h5A5A_5A5A);
        load_entry(32'h0000_0000, 32'h1234_5678);
        read_entry(8'd0);
        read_entry(8'd1);
        read_entry(8'd2);
        read_entry(8'd3);
        read_entry(8'd255);
        patch_entry(1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
        patch_entry(1'b0, 32'h0000_0000, 32'hDEAD_BEEF);
        // start now past the last entry
        patch_entry(1'b0, 32'h0000_0000, 32'h0BAD_F00D);
        read_entry(8'd3);
        erase_entry(1'b1, 32'h0000_0000);
        erase_entry(1'b0, 32'hFFFF_FFFF);
        // bound now below the remaining match
        erase_entry(1'b0, 32'hA5A5_A5A5);
        patch_entry(1'b1, 32'hA5A5_A5A5, 32'h0000_0000);
        // start left beyond the shrunken table
        patch_entry(1'b0, 32'h0000_0000, 32'h5555_5555);
        read_entry(8'd0);
        read_entry(8'd1);
        read_entry(8'd2);

        while (sent_items < FILL_START)
            run_batch();
        fill_phase();
        while (sent_items < ITEM_GOAL)
            run_batch();
        if (valid_held)
            item_valid <= 1'b0;

        // one edge so the monitor has noted the last word, then drain
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
